@@ rtl/ppm_pkg.sv @@
package ppm_pkg;

   localparam int unsigned SampleWidth = 12;
   localparam int unsigned DelayWidth  = 16;
   localparam int unsigned TimeWidth   = 32;
   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;

   // register map, word index = paddr[3:2]
   typedef enum logic [1:0] {
      REG_MISMATCH_LIMIT = 2'd0,
      REG_FAULT_DELAY    = 2'd1,
      REG_CLEAR_DELAY    = 2'd2,
      REG_HEARTBEAT      = 2'd3
   } reg_index_type;

   localparam logic [SampleWidth-1:0] MismatchLimitReset = 12'd409;
   localparam logic [DelayWidth-1:0]  FaultDelayReset    = 16'd100;
   localparam logic [DelayWidth-1:0]  ClearDelayReset    = 16'd100;
   localparam logic [DelayWidth-1:0]  HeartbeatReset     = 16'd100;

   typedef struct packed {
      logic [SampleWidth-1:0] sensor_a;
      logic [SampleWidth-1:0] sensor_b;
      logic                   brake_pin;
      logic [TimeWidth-1:0]   now_ms;
   } req_type;

   typedef struct packed {
      logic mismatch_seen;
      logic drive_cut;
      logic clearing;
      logic brake_pressed;
      logic send_status;
   } rsp_type;

   typedef struct packed {
      logic [SampleWidth-1:0] mismatch_limit;
      logic [DelayWidth-1:0]  fault_delay_ms;
      logic [DelayWidth-1:0]  clear_delay_ms;
      logic [DelayWidth-1:0]  heartbeat_ms;
   } cfg_type;

endpackage

@@ rtl/ppm_csr.sv @@
module ppm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ppm_pkg::CsrAddrWidth-1:0]   paddr,
   input  logic [ppm_pkg::CsrDataWidth-1:0]   pwdata,
   output logic [ppm_pkg::CsrDataWidth-1:0]   prdata,
   output logic                               pready,
   output ppm_pkg::cfg_type                   cfg
);

   ppm_pkg::cfg_type       cfg_ff;
   ppm_pkg::reg_index_type index;
   logic                   write_en;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite && pready;
   assign index    = ppm_pkg::reg_index_type'(paddr[3:2]);
   assign cfg      = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mismatch_limit <= ppm_pkg::MismatchLimitReset;
         cfg_ff.fault_delay_ms <= ppm_pkg::FaultDelayReset;
         cfg_ff.clear_delay_ms <= ppm_pkg::ClearDelayReset;
         cfg_ff.heartbeat_ms   <= ppm_pkg::HeartbeatReset;
      end else if (write_en) begin
         unique case (index)
            ppm_pkg::REG_MISMATCH_LIMIT: begin
               cfg_ff.mismatch_limit <= pwdata[ppm_pkg::SampleWidth-1:0];
            end
            ppm_pkg::REG_FAULT_DELAY: begin
               cfg_ff.fault_delay_ms <= pwdata[ppm_pkg::DelayWidth-1:0];
            end
            ppm_pkg::REG_CLEAR_DELAY: begin
               cfg_ff.clear_delay_ms <= pwdata[ppm_pkg::DelayWidth-1:0];
            end
            ppm_pkg::REG_HEARTBEAT: begin
               cfg_ff.heartbeat_ms <= pwdata[ppm_pkg::DelayWidth-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (index)
         ppm_pkg::REG_MISMATCH_LIMIT: begin
            prdata[ppm_pkg::SampleWidth-1:0] = cfg_ff.mismatch_limit;
         end
         ppm_pkg::REG_FAULT_DELAY: begin
            prdata[ppm_pkg::DelayWidth-1:0] = cfg_ff.fault_delay_ms;
         end
         ppm_pkg::REG_CLEAR_DELAY: begin
            prdata[ppm_pkg::DelayWidth-1:0] = cfg_ff.clear_delay_ms;
         end
         ppm_pkg::REG_HEARTBEAT: begin
            prdata[ppm_pkg::DelayWidth-1:0] = cfg_ff.heartbeat_ms;
         end
         default: begin
         end
      endcase
   end

endmodule

@@ rtl/pedal_plausibility_monitor.sv @@
// Pedal plausibility monitor: checks two pedal position samples against each
// other and decides when drive power must be cut and when it may be restored.
//
// Request channel (req_valid / req_stall / req_data): one request per sensor
// sample with both converter readings, the brake pin and a millisecond time.
// Response channel (rsp_valid / rsp_stall / rsp_data): exactly one response per
// request, in order, with the status bits and a flag telling that a status
// frame is due.
// Configuration (csr_*): four word registers at 0x0, 0x4, 0x8, 0xC for the
// mismatch limit, fault delay, clear delay and heartbeat; write only while idle.
//
// An accepted request sits in the input register while the check and timer
// update run, and the result is then loaded into the response register.
// Throughput is one request per cycle while rsp_stall is low; a request can
// be taken while a finished response is still waiting.
// Reset clears the valid bits of both pipeline registers, all timers and
// flags, and loads the register defaults. While rsp_stall is high the
// response holds, the input register fills, and req_stall rises once it is
// occupied.
module pedal_plausibility_monitor (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  ppm_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output ppm_pkg::rsp_type                 rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ppm_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [ppm_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [ppm_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                             csr_pready
);

   ppm_pkg::cfg_type cfg;

   ppm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // pipeline registers
   logic             in_valid_ff;
   ppm_pkg::req_type in_data_ff;
   logic             rsp_valid_ff;
   ppm_pkg::rsp_type rsp_data_ff;
   logic             advance;

   // monitor state
   logic                            mismatch_flag_ff, mismatch_flag_in;
   logic [ppm_pkg::TimeWidth-1:0]   mismatch_start_ff, mismatch_start_in;
   logic                            cut_flag_ff, cut_flag_in;
   logic                            clear_flag_ff, clear_flag_in;
   logic [ppm_pkg::TimeWidth-1:0]   clear_start_ff, clear_start_in;
   logic [2:0]                      last_status_ff, last_status_in;
   logic [ppm_pkg::TimeWidth-1:0]   last_send_ff, last_send_in;

   logic [ppm_pkg::SampleWidth-1:0] diff;
   logic                            disagree;
   logic [ppm_pkg::TimeWidth-1:0]   mismatch_age;
   logic [ppm_pkg::TimeWidth-1:0]   clear_age;
   logic [ppm_pkg::TimeWidth-1:0]   send_age;
   logic [2:0]                      status;
   logic                            send;
   ppm_pkg::rsp_type                result;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   always_comb begin
      diff = (in_data_ff.sensor_a >= in_data_ff.sensor_b) ?
             (in_data_ff.sensor_a - in_data_ff.sensor_b) :
             (in_data_ff.sensor_b - in_data_ff.sensor_a);
      disagree     = diff > cfg.mismatch_limit;
      mismatch_age = in_data_ff.now_ms - mismatch_start_ff;
      clear_age    = in_data_ff.now_ms - clear_start_ff;
      send_age     = in_data_ff.now_ms - last_send_ff;

      mismatch_flag_in  = mismatch_flag_ff;
      mismatch_start_in = mismatch_start_ff;
      cut_flag_in       = cut_flag_ff;
      clear_flag_in     = clear_flag_ff;
      clear_start_in    = clear_start_ff;

      if (disagree) begin
         if (!mismatch_flag_ff) begin
            // first disagreeing sample starts the fault timer and ends any clearing; it never cuts power
            mismatch_start_in = in_data_ff.now_ms;
            mismatch_flag_in  = 1'b1;
            clear_flag_in     = 1'b0;
         end else if (mismatch_age > {16'd0, cfg.fault_delay_ms}) begin
            cut_flag_in = 1'b1;
         end
      end else begin
         mismatch_flag_in = 1'b0;
         if (cut_flag_ff) begin
            if (!clear_flag_ff) begin
               clear_start_in = in_data_ff.now_ms;
               clear_flag_in  = 1'b1;
            end else if (clear_age > {16'd0, cfg.clear_delay_ms}) begin
               cut_flag_in   = 1'b0;
               clear_flag_in = 1'b0;
            end
         end
      end

      status = {clear_flag_in, cut_flag_in, mismatch_flag_in};
      send   = (status != last_status_ff) || (send_age >= {16'd0, cfg.heartbeat_ms});

      last_status_in = send ? status : last_status_ff;
      last_send_in   = send ? in_data_ff.now_ms : last_send_ff;

      result.mismatch_seen = mismatch_flag_in;
      result.drive_cut     = cut_flag_in;
      result.clearing      = clear_flag_in;
      result.brake_pressed = !in_data_ff.brake_pin;
      result.send_status   = send;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mismatch_flag_ff  <= 1'b0;
         mismatch_start_ff <= '0;
         cut_flag_ff       <= 1'b0;
         clear_flag_ff     <= 1'b0;
         clear_start_ff    <= '0;
         last_status_ff    <= '0;
         last_send_ff      <= '0;
      end else if (advance) begin
         mismatch_flag_ff  <= mismatch_flag_in;
         mismatch_start_ff <= mismatch_start_in;
         cut_flag_ff       <= cut_flag_in;
         clear_flag_ff     <= clear_flag_in;
         clear_start_ff    <= clear_start_in;
         last_status_ff    <= last_status_in;
         last_send_ff      <= last_send_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   // clearing only runs while power cut is latched, never during a mismatch
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.clearing || rsp_data_ff.drive_cut))
      else $error("clearing reported without power cut");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.clearing && rsp_data_ff.mismatch_seen))
      else $error("clearing reported during a mismatch");

   // a held request must sit in a full input register behind a stalled response
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled without a blocked response");

   assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid_ff && !cut_flag_ff && !in_valid_ff))
      else $error("pipeline or power cut not cleared by reset");

endmodule
